// ----- rtl/mlpsgd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsgd_pkg
// Shared types, codes and saturation helpers for the perceptron trainer.
// ----------------------------------------------------------------------------
package mlpsgd_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic signed [32:0] operand_type;
   typedef logic signed [65:0] wide_type;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_INFER = 2'd1;
   localparam logic [1:0] FUNC_TRAIN = 2'd2;

   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   function automatic word_type sat_word(input wide_type v);
      word_type r;
      if (v > 66'(WORD_MAX)) begin
         r = WORD_MAX;
      end else if (v < 66'(WORD_MIN)) begin
         r = WORD_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mlp_one_hidden_relu_sgd_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_one_hidden_relu_sgd_unit
// One-hidden-layer ReLU perceptron with online SGD training, Q16.16.
// ----------------------------------------------------------------------------
// Items arrive on the req_ channel. A weight write or a feature that is not
// the last of its sample is taken while the unit is idle. The last feature
// starts a forward pass on one shared multiply-accumulate unit; every step
// runs memory read, multiply, round and accumulate, and write back in turn.
// A training sample then goes on to update the weights. The result sits in
// an output register on the rsp_ channel while the update runs; req_ready is
// low until the sequencer is idle again. If the receiver stalls, the next
// result waits until the previous one transfers. After reset the weight
// memory is cleared, one entry a cycle, all NUM_HIDDEN*(NUM_INPUTS+2)+1
// entries (193 by default), with req_ready low. The learning rate must be
// written through csr_ only while the unit is idle; the unit itself does
// not enforce this.
// ----------------------------------------------------------------------------
module mlp_one_hidden_relu_sgd_unit #(
   parameter int NUM_INPUTS = 4,
   parameter int NUM_HIDDEN = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [1:0]                  req_func,
   input  wire  mlpsgd_pkg::word_type  req_feature_value,
   input  wire                         req_last_feature,
   input  wire  mlpsgd_pkg::word_type  req_target_value,
   input  wire  [7:0]                  req_weight_index,
   input  wire  mlpsgd_pkg::word_type  req_weight_value,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output mlpsgd_pkg::word_type        rsp_prediction,
   output mlpsgd_pkg::word_type        rsp_prediction_error,
   output logic                        rsp_was_training,
   input  wire                         csr_write_enable,
   input  wire  [16:0]                 csr_write_data
);
   import mlpsgd_pkg::*;

   localparam int NHW  = NUM_HIDDEN * NUM_INPUTS;
   localparam int HBB  = NHW;
   localparam int OWB  = NHW + NUM_HIDDEN;
   localparam int OBI  = NHW + 2 * NUM_HIDDEN;
   localparam int NW   = OBI + 1;
   localparam int WAW  = $clog2(NW);
   localparam int IW   = $clog2(NUM_HIDDEN + 1);
   localparam int JW   = $clog2(NUM_INPUTS + 1);
   localparam int HA   = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
   localparam int FA   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam logic [16:0] LR_RESET = 17'd66;
   localparam operand_type ONE = 33'sd1 <<< FRAC_BITS;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_FH    = 4'd2;
   localparam logic [3:0] S_FO    = 4'd3;
   localparam logic [3:0] S_EMIT  = 4'd4;
   localparam logic [3:0] S_STEP  = 4'd5;
   localparam logic [3:0] S_OW    = 4'd6;
   localparam logic [3:0] S_DELTA = 4'd7;
   localparam logic [3:0] S_HSTEP = 4'd8;
   localparam logic [3:0] S_HW    = 4'd9;

   localparam logic [1:0] PH_WB = 2'd3;

   logic [3:0]     state_ff, state_in;
   logic [1:0]     phase_ff, phase_in;
   logic [IW-1:0]  i_ff, i_in;
   logic [JW-1:0]  j_ff, j_in;
   logic [JW-1:0]  cnt_ff, cnt_in;
   logic [WAW-1:0] clr_ff, clr_in;
   logic [16:0]    lr_ff, lr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           train_ff, train_in;
   word_type       acc_ff, acc_in;
   word_type       err_ff, err_in;
   word_type       step_ff, step_in;
   word_type       delta_ff, delta_in;
   word_type       target_ff, target_in;
   word_type       pred_ff, pred_in;
   word_type       rsp_pred_ff, rsp_pred_in;
   word_type       rsp_err_ff, rsp_err_in;
   logic           rsp_train_ff, rsp_train_in;

   word_type wmem [NW];
   word_type amem [NUM_HIDDEN];
   word_type fmem [NUM_INPUTS];
   word_type w_rd_ff, a_rd_ff, f_rd_ff;

   logic           w_we, a_we, f_we;
   logic [WAW-1:0] w_wa, w_ra;
   word_type       w_wd, a_wd, f_wd;
   logic [FA-1:0]  f_wa;

   operand_type mac_a, mac_b;
   word_type    mac_addend, mac_result;

   logic        accept, j_body, i_body;
   logic [31:0] ie, je, row_addr, col_addr;
   word_type    err_calc;

   mlpsgd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock  (clock),
      .op_a   (mac_a),
      .op_b   (mac_b),
      .addend (mac_addend),
      .result (mac_result)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      ie       = 32'(i_ff);
      je       = 32'(j_ff);
      j_body   = (j_ff < JW'(NUM_INPUTS));
      i_body   = (i_ff < IW'(NUM_HIDDEN));
      row_addr = j_body ? (ie * NUM_INPUTS + je) : (HBB + ie);
      col_addr = i_body ? (OWB + ie) : OBI;
      err_calc = train_ff ? sat_word(66'(target_ff) - 66'(pred_ff)) : '0;
   end

   always_comb begin
      unique case (state_ff)
         S_FH, S_HW:  w_ra = WAW'(row_addr);
         S_FO, S_OW:  w_ra = WAW'(col_addr);
         default:     w_ra = WAW'(OWB + ie);
      endcase
   end

   always_comb begin
      mac_a      = ONE;
      mac_b      = ONE;
      mac_addend = '0;
      unique case (state_ff)
         S_FH: begin
            mac_a      = j_body ? 33'(f_rd_ff) : 33'(w_rd_ff);
            mac_b      = j_body ? 33'(w_rd_ff) : ONE;
            mac_addend = acc_ff;
         end
         S_FO: begin
            mac_a      = i_body ? 33'(a_rd_ff) : 33'(w_rd_ff);
            mac_b      = i_body ? 33'(w_rd_ff) : ONE;
            mac_addend = acc_ff;
         end
         S_STEP: begin
            mac_a = $signed({16'd0, lr_ff});
            mac_b = 33'(err_ff);
         end
         S_OW: begin
            mac_a      = 33'(step_ff);
            mac_b      = i_body ? 33'(a_rd_ff) : ONE;
            mac_addend = w_rd_ff;
         end
         S_DELTA: begin
            mac_a = 33'(err_ff);
            mac_b = 33'(w_rd_ff);
         end
         S_HSTEP: begin
            mac_a = $signed({16'd0, lr_ff});
            mac_b = 33'(delta_ff);
         end
         S_HW: begin
            mac_a      = 33'(step_ff);
            mac_b      = j_body ? 33'(f_rd_ff) : ONE;
            mac_addend = w_rd_ff;
         end
         default: begin
            mac_a = ONE;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff + 2'd1;
      i_in         = i_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      lr_in        = csr_write_enable ? csr_write_data : lr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      train_in     = train_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      step_in      = step_ff;
      delta_in     = delta_ff;
      target_in    = target_ff;
      pred_in      = pred_ff;
      rsp_pred_in  = rsp_pred_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_train_in = rsp_train_ff;
      w_we = 1'b0;
      w_wa = w_ra;
      w_wd = mac_result;
      a_we = 1'b0;
      a_wd = (mac_result > 0) ? mac_result : '0;
      f_we = 1'b0;
      f_wa = cnt_ff[FA-1:0];
      f_wd = req_feature_value;

      unique case (state_ff)
         S_CLEAR: begin
            phase_in = '0;
            w_we     = 1'b1;
            w_wa     = clr_ff;
            w_wd     = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == WAW'(NW - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            phase_in = '0;
            if (accept) begin
               if (req_func == FUNC_WRITE) begin
                  w_we = (32'(req_weight_index) < NW);
                  w_wa = WAW'(req_weight_index);
                  w_wd = req_weight_value;
               end else if (req_func == FUNC_INFER || req_func == FUNC_TRAIN) begin
                  if (cnt_ff < JW'(NUM_INPUTS)) begin
                     f_we   = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
                  if (req_last_feature) begin
                     cnt_in    = '0;
                     train_in  = (req_func == FUNC_TRAIN);
                     target_in = req_target_value;
                     i_in      = '0;
                     j_in      = '0;
                     acc_in    = '0;
                     state_in  = S_FH;
                  end
               end
            end
         end
         S_FH: begin
            if (phase_ff == PH_WB) begin
               if (j_body) begin
                  acc_in = mac_result;
                  j_in   = j_ff + 1'b1;
               end else begin
                  a_we   = 1'b1;
                  acc_in = '0;
                  j_in   = '0;
                  if (i_ff == IW'(NUM_HIDDEN - 1)) begin
                     i_in     = '0;
                     state_in = S_FO;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end
            end
         end
         S_FO: begin
            if (phase_ff == PH_WB) begin
               if (i_body) begin
                  acc_in = mac_result;
                  i_in   = i_ff + 1'b1;
               end else begin
                  pred_in  = mac_result;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            phase_in = '0;
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pred_in  = pred_ff;
               rsp_err_in   = err_calc;
               rsp_train_in = train_ff;
               err_in       = err_calc;
               i_in         = '0;
               j_in         = '0;
               state_in     = train_ff ? S_STEP : S_IDLE;
            end
         end
         S_STEP: begin
            if (phase_ff == PH_WB) begin
               step_in  = mac_result;
               state_in = S_OW;
            end
         end
         S_OW: begin
            if (phase_ff == PH_WB) begin
               w_we = 1'b1;
               if (i_body) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  i_in     = '0;
                  state_in = S_DELTA;
               end
            end
         end
         S_DELTA: begin
            if (phase_ff == PH_WB) begin
               delta_in = (a_rd_ff > 0) ? mac_result : '0;
               state_in = S_HSTEP;
            end
         end
         S_HSTEP: begin
            if (phase_ff == PH_WB) begin
               step_in  = mac_result;
               j_in     = '0;
               state_in = S_HW;
            end
         end
         S_HW: begin
            if (phase_ff == PH_WB) begin
               w_we = 1'b1;
               if (j_body) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  if (i_ff == IW'(NUM_HIDDEN - 1)) begin
                     i_in     = '0;
                     state_in = S_IDLE;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_DELTA;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         lr_ff        <= LR_RESET;
         rsp_valid_ff <= 1'b0;
         train_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         lr_ff        <= lr_in;
         rsp_valid_ff <= rsp_valid_in;
         train_ff     <= train_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      err_ff       <= err_in;
      step_ff      <= step_in;
      delta_ff     <= delta_in;
      target_ff    <= target_in;
      pred_ff      <= pred_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_train_ff <= rsp_train_in;
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_wa] <= w_wd;
      end
      w_rd_ff <= wmem[w_ra];
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         amem[i_ff[HA-1:0]] <= a_wd;
      end
      a_rd_ff <= amem[i_ff[HA-1:0]];
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fmem[f_wa] <= f_wd;
      end
      f_rd_ff <= fmem[j_ff[FA-1:0]];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_prediction       = rsp_pred_ff;
   assign rsp_prediction_error = rsp_err_ff;
   assign rsp_was_training     = rsp_train_ff;

endmodule
`default_nettype wire

// ----- rtl/mlpsgd_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mlpsgd_mac
// Two-stage multiply, round, saturate and saturating accumulate unit.
// ----------------------------------------------------------------------------
module mlpsgd_mac #(
   parameter int FRAC_BITS = 16
) (
   input  wire                           clock,
   input  mlpsgd_pkg::operand_type       op_a,
   input  mlpsgd_pkg::operand_type       op_b,
   input  mlpsgd_pkg::word_type          addend,
   output mlpsgd_pkg::word_type          result
);
   import mlpsgd_pkg::*;

   localparam wide_type HALF = 66'sd1 <<< (FRAC_BITS - 1);

   wide_type prod_ff;
   word_type addend_ff;
   word_type result_ff;
   wide_type rounded;
   word_type product_q;

   always_comb begin
      rounded   = (prod_ff + HALF) >>> FRAC_BITS;
      product_q = sat_word(rounded);
   end

   always_ff @(posedge clock) begin
      prod_ff   <= op_a * op_b;
      addend_ff <= addend;
      result_ff <= sat_word(66'(product_q) + 66'(addend_ff));
   end

   assign result = result_ff;

endmodule
`default_nettype wire
